@@ hdl/acdz_pkg.sv @@
// ----------------------------------------------------------------------------
// Axis calibration package
// Shared types and constants for the auto-calibrating deadzone scaler.
// ----------------------------------------------------------------------------
package acdz_pkg;

  localparam int unsigned SampleW    = 16;
  localparam int unsigned QuotW      = 15;
  localparam int unsigned CntW       = $clog2(QuotW + 1);
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned MaskW      = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [SampleW-1:0] UnsetPoint = 16'hFFFF;
  localparam logic [SampleW-1:0] HalfFull   = 16'h7FFF;
  localparam logic [SampleW-1:0] UpperBase  = 16'h8000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFloatMask  = 2'd0,
    CfgDzMin      = 2'd1,
    CfgDzCenter   = 2'd2,
    CfgDzMax      = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    JobFail   = 2'd0,
    JobZero   = 2'd1,
    JobFull   = 2'd2,
    JobDivide = 2'd3
  } job_kind_e;

  typedef enum logic {
    BackIdle = 1'b0,
    BackDiv  = 1'b1
  } back_state_e;

  typedef struct packed {
    job_kind_e          kind;
    logic               upper;
    logic               changed;
    logic [SampleW-1:0] num;
    logic [SampleW-1:0] den;
  } job_t;

endpackage

@@ hdl/axis_autocal_deadzone_scaler.sv @@
// ----------------------------------------------------------------------------
// Axis auto-calibration with deadzone scaler
// Tracks min, center and max of a raw axis and maps samples onto a 16-bit
// calibrated position with per-point deadzones.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on push/full; a sample is taken when push is high and full
//   is low. Results leave on empty/pop; the word on the result ports is taken
//   when pop is high and empty is low.
//   Configuration is written on cfg_valid_i/cfg_ready_o (always ready) with
//   cfg_index_i selecting float mask, min, center or max deadzone; write it
//   only while no sample is in flight.
//   The front updates the calibration points and classifies each sample
//   combinationally and hands it to a job queue of QueueDepth entries.
//   A saturated or failed sample passes from its queue entry into the output
//   register. A sample inside its span runs through the back in order (load,
//   15 restoring divider steps, output); the back takes no new job until that
//   word is in the output register.
//   Reset clears the queue and output register and sets all points unset
//   and the float mask to all ones.
//   When the receiver stalls the result word holds, the back waits, the
//   queue fills and full rises.
// ----------------------------------------------------------------------------
module axis_autocal_deadzone_scaler #(
  parameter int unsigned QueueDepth = acdz_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [acdz_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [acdz_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [acdz_pkg::SampleW-1:0]  raw_sample_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [acdz_pkg::SampleW-1:0]  scaled_position_o,
  output logic                          calibrated_o,
  output logic                          calibration_changed_o
);

  acdz_pkg::job_t job_in, job_out;
  logic           accept, job_empty, job_rd;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  acdz_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (acdz_pkg::cfg_reg_e'(cfg_index_i)),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .raw_sample_i (raw_sample_i),
    .job_o        (job_in)
  );

  acdz_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept),
    .wr_data_i (job_in),
    .full_o    (full),
    .rd_en_i   (job_rd),
    .rd_data_o (job_out),
    .empty_o   (job_empty)
  );

  acdz_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .job_i                 (job_out),
    .job_empty_i           (job_empty),
    .job_rd_o              (job_rd),
    .pop_i                 (pop),
    .empty_o               (empty),
    .scaled_position_o     (scaled_position_o),
    .calibrated_o          (calibrated_o),
    .calibration_changed_o (calibration_changed_o)
  );

endmodule

@@ hdl/acdz_queue.sv @@
// ----------------------------------------------------------------------------
// Job queue
// Small register queue between the classifying front and the dividing back.
// ----------------------------------------------------------------------------
module acdz_queue #(
  parameter int unsigned Depth = acdz_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  acdz_pkg::job_t wr_data_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output acdz_pkg::job_t rd_data_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  acdz_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ hdl/acdz_front.sv @@
// ----------------------------------------------------------------------------
// Calibration front
// Holds configuration and calibration points, updates the points per sample
// and classifies the sample into a job for the back.
// ----------------------------------------------------------------------------
module acdz_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  acdz_pkg::cfg_reg_e             cfg_index_i,
  input  logic [acdz_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           accept_i,
  input  logic [acdz_pkg::SampleW-1:0]   raw_sample_i,
  output acdz_pkg::job_t                 job_o
);

  logic [acdz_pkg::MaskW-1:0]   mask_q;
  logic [acdz_pkg::SampleW-1:0] dz_min_q, dz_ctr_q, dz_max_q;
  logic [acdz_pkg::SampleW-1:0] min_q, min_d, ctr_q, ctr_d, max_q, max_d;

  logic               min_set, max_set, moved, ctr_upd, fail, upper;
  logic signed [16:0] diff, half;
  logic signed [17:0] lo, hi, r;
  logic [17:0]        num_w, den_w;

  always_comb begin
    min_set = mask_q[0] && ((raw_sample_i < min_q) || (min_q == acdz_pkg::UnsetPoint));
    max_set = mask_q[2] && ((raw_sample_i > max_q) || (max_q == acdz_pkg::UnsetPoint));
    moved   = min_set || max_set;
    min_d   = min_set ? raw_sample_i : min_q;
    max_d   = max_set ? raw_sample_i : max_q;
    ctr_upd = mask_q[1] && (moved || (ctr_q == acdz_pkg::UnsetPoint));
    diff    = $signed({1'b0, max_d}) - $signed({1'b0, min_d});
    // halve toward zero
    half    = (diff + $signed({16'd0, diff[16]})) >>> 1;
    ctr_d   = ctr_upd ? (min_d + half[15:0]) : ctr_q;
    fail    = (min_d == ctr_d) || (ctr_d == max_d);
    upper   = (raw_sample_i >= ctr_d);
    r       = $signed({2'b00, raw_sample_i});
    if (upper) begin
      lo = $signed({2'b00, ctr_d}) + $signed({2'b00, dz_ctr_q});
      hi = $signed({2'b00, max_d}) - $signed({2'b00, dz_max_q});
    end else begin
      lo = $signed({2'b00, min_d}) + $signed({2'b00, dz_min_q});
      hi = $signed({2'b00, ctr_d}) - $signed({2'b00, dz_ctr_q});
    end
    num_w = 18'(r - lo);
    den_w = 18'(hi - lo);

    job_o.upper   = upper;
    job_o.changed = moved;
    job_o.num     = num_w[15:0];
    job_o.den     = den_w[15:0];
    if (fail) begin
      job_o.kind = acdz_pkg::JobFail;
    end else if (r <= lo) begin
      job_o.kind = acdz_pkg::JobZero;
    end else if (r >= hi) begin
      job_o.kind = acdz_pkg::JobFull;
    end else begin
      job_o.kind = acdz_pkg::JobDivide;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= 3'b111;
      dz_min_q <= '0;
      dz_ctr_q <= '0;
      dz_max_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        acdz_pkg::CfgFloatMask: mask_q   <= cfg_data_i[acdz_pkg::MaskW-1:0];
        acdz_pkg::CfgDzMin:     dz_min_q <= cfg_data_i;
        acdz_pkg::CfgDzCenter:  dz_ctr_q <= cfg_data_i;
        acdz_pkg::CfgDzMax:     dz_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= acdz_pkg::UnsetPoint;
      ctr_q <= acdz_pkg::UnsetPoint;
      max_q <= acdz_pkg::UnsetPoint;
    end else if (accept_i) begin
      min_q <= min_d;
      ctr_q <= ctr_d;
      max_q <= max_d;
    end
  end

endmodule

@@ hdl/acdz_back.sv @@
// ----------------------------------------------------------------------------
// Scaling back
// Takes jobs from the queue, runs the restoring divider for in-span samples
// and holds the finished word in the output register.
// ----------------------------------------------------------------------------
module acdz_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  acdz_pkg::job_t               job_i,
  input  logic                         job_empty_i,
  output logic                         job_rd_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic [acdz_pkg::SampleW-1:0] scaled_position_o,
  output logic                         calibrated_o,
  output logic                         calibration_changed_o
);

  localparam int unsigned NumW = acdz_pkg::SampleW + acdz_pkg::QuotW;
  localparam int unsigned AccW = NumW;

  acdz_pkg::back_state_e state_q, state_d;

  logic [AccW-1:0]              acc_q, acc_d;
  logic [acdz_pkg::SampleW-1:0] den_q;
  logic [acdz_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic                         upper_q, changed_q;

  logic                         out_valid_q, out_valid_d;
  logic [acdz_pkg::SampleW-1:0] pos_q, pos_d;
  logic                         cal_q, cal_d, chg_q, chg_d;

  logic            slot_free, load_div, step, load_out;
  logic [NumW-1:0] num_full;
  logic [16:0]     trial;
  logic            ge;
  logic [15:0]     rem_n;

  assign slot_free = !out_valid_q || pop_i;
  assign num_full  = {job_i.num, {acdz_pkg::QuotW{1'b0}}} - NumW'(job_i.num);
  assign trial     = {acc_q[AccW-1:acdz_pkg::QuotW], acc_q[acdz_pkg::QuotW-1]};
  assign ge        = (trial >= {1'b0, den_q});
  assign rem_n     = ge ? 16'(trial - {1'b0, den_q}) : trial[15:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      acdz_pkg::BackIdle: begin
        if (!job_empty_i && (job_i.kind == acdz_pkg::JobDivide)) begin
          state_d = acdz_pkg::BackDiv;
        end
      end
      acdz_pkg::BackDiv: begin
        if ((cnt_q == '0) && slot_free) begin
          state_d = acdz_pkg::BackIdle;
        end
      end
      default: state_d = acdz_pkg::BackIdle;
    endcase
  end

  always_comb begin
    job_rd_o = 1'b0;
    load_div = 1'b0;
    step     = 1'b0;
    load_out = 1'b0;
    pos_d    = pos_q;
    cal_d    = cal_q;
    chg_d    = chg_q;
    unique case (state_q)
      acdz_pkg::BackIdle: begin
        cal_d = 1'b1;
        chg_d = job_i.changed;
        case (job_i.kind)
          acdz_pkg::JobFail: begin
            pos_d = '0;
            cal_d = 1'b0;
          end
          acdz_pkg::JobZero: pos_d = job_i.upper ? acdz_pkg::UpperBase : '0;
          default:           pos_d = acdz_pkg::HalfFull | (job_i.upper ? acdz_pkg::UpperBase : '0);
        endcase
        if (!job_empty_i) begin
          if (job_i.kind == acdz_pkg::JobDivide) begin
            job_rd_o = 1'b1;
            load_div = 1'b1;
          end else if (slot_free) begin
            job_rd_o = 1'b1;
            load_out = 1'b1;
          end
        end
      end
      acdz_pkg::BackDiv: begin
        pos_d = {upper_q, acc_q[acdz_pkg::QuotW-1:0]};
        cal_d = 1'b1;
        chg_d = changed_q;
        if (cnt_q != '0) begin
          step = 1'b1;
        end else if (slot_free) begin
          load_out = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (load_div) begin
      acc_d = num_full;
      cnt_d = acdz_pkg::CntW'(acdz_pkg::QuotW);
    end else if (step) begin
      acc_d = {rem_n, acc_q[acdz_pkg::QuotW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
    end
    out_valid_d = load_out ? 1'b1 : (pop_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= acdz_pkg::BackIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (load_div) begin
      den_q     <= job_i.den;
      upper_q   <= job_i.upper;
      changed_q <= job_i.changed;
    end
    if (load_out) begin
      pos_q <= pos_d;
      cal_q <= cal_d;
      chg_q <= chg_d;
    end
  end

  assign empty_o               = !out_valid_q;
  assign scaled_position_o     = pos_q;
  assign calibrated_o          = cal_q;
  assign calibration_changed_o = chg_q;

endmodule

@@ hdl/acdz_checker.sv @@
// ----------------------------------------------------------------------------
// Scaler port checker
// Port-level properties of the axis scaler, bound to the top level.
// ----------------------------------------------------------------------------
module acdz_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [acdz_pkg::SampleW-1:0] scaled_position_o,
  input logic                         calibrated_o
);

  assert property (@(posedge clk_i) !rst_ni |-> (empty && !full))
    else $error("queue or result word not clear in reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(scaled_position_o) && $stable(calibrated_o)))
    else $error("stalled result word changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !calibrated_o) |-> (scaled_position_o == '0))
    else $error("uncalibrated word with non-zero position");

endmodule

bind axis_autocal_deadzone_scaler acdz_checker u_acdz_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .full              (full),
  .empty             (empty),
  .pop               (pop),
  .scaled_position_o (scaled_position_o),
  .calibrated_o      (calibrated_o)
);

@@ test/axis_autocal_deadzone_scaler_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Axis auto-calibration scaler testbench
// Drives raw samples through the push/full side and pops result words on the
// empty/pop side, both with random idle bursts. An in-bench calibration model
// predicts every word, which is then compared field by field. The run covers
// unset points, deadzone bounds, frozen and out-of-order points, and random
// phases with changing float masks and deadzones.
// ----------------------------------------------------------------------------
module axis_autocal_deadzone_scaler_tb;

  typedef struct packed {
    logic [acdz_pkg::SampleW-1:0] position;
    logic                         calibrated;
    logic                         changed;
  } axis_word_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [acdz_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [acdz_pkg::CfgDataW-1:0] cfg_data_i;
  logic                          push;
  logic                          full;
  logic [acdz_pkg::SampleW-1:0]  raw_sample_i;
  logic                          empty;
  logic                          pop;
  logic [acdz_pkg::SampleW-1:0]  scaled_position_o;
  logic                          calibrated_o;
  logic                          calibration_changed_o;

  logic [acdz_pkg::MaskW-1:0]    reg_float_mask;
  logic [acdz_pkg::SampleW-1:0]  reg_dz_min;
  logic [acdz_pkg::SampleW-1:0]  reg_dz_center;
  logic [acdz_pkg::SampleW-1:0]  reg_dz_max;
  logic [acdz_pkg::SampleW-1:0]  cal_min;
  logic [acdz_pkg::SampleW-1:0]  cal_center;
  logic [acdz_pkg::SampleW-1:0]  cal_max;

  axis_word_t          pending_words[$];
  axis_word_t          oldest_word;
  int                  err_cnt;
  bit                  idle_on;
  int                  win_lo;
  int                  win_hi;

  axis_autocal_deadzone_scaler DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .push                  (push),
    .full                  (full),
    .raw_sample_i          (raw_sample_i),
    .empty                 (empty),
    .pop                   (pop),
    .scaled_position_o     (scaled_position_o),
    .calibrated_o          (calibrated_o),
    .calibration_changed_o (calibration_changed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic axis_word_t calibrate_sample(
    input logic [acdz_pkg::SampleW-1:0] raw
  );
    axis_word_t w;
    logic       moved;
    logic       upper;
    int         span;
    int         mid;
    longint     lo;
    longint     hi;
    longint     r;
    longint     scaled;
    longint     full_scale;
    moved = 1'b0;
    if (reg_float_mask[0] && (raw < cal_min || cal_min == acdz_pkg::UnsetPoint)) begin
      cal_min = raw;
      moved   = 1'b1;
    end
    if (reg_float_mask[2] && (raw > cal_max || cal_max == acdz_pkg::UnsetPoint)) begin
      cal_max = raw;
      moved   = 1'b1;
    end
    if (reg_float_mask[1] && (moved || cal_center == acdz_pkg::UnsetPoint)) begin
      span       = int'(cal_max) - int'(cal_min);
      mid        = span / 2 + int'(cal_min);
      cal_center = mid[acdz_pkg::SampleW-1:0];
    end
    w.changed = moved;
    if (cal_min == cal_center || cal_center == cal_max) begin
      w.position   = '0;
      w.calibrated = 1'b0;
      return w;
    end
    upper = (raw >= cal_center);
    if (upper) begin
      lo = cal_center;
      lo = lo + reg_dz_center;
      hi = cal_max;
      hi = hi - reg_dz_max;
    end else begin
      lo = cal_min;
      lo = lo + reg_dz_min;
      hi = cal_center;
      hi = hi - reg_dz_center;
    end
    r          = raw;
    full_scale = acdz_pkg::HalfFull;
    if (r <= lo) scaled = 0;
    else if (r >= hi) scaled = full_scale;
    else scaled = ((r - lo) * full_scale) / (hi - lo);
    if (upper) scaled = scaled + acdz_pkg::UpperBase;
    w.position   = scaled[acdz_pkg::SampleW-1:0];
    w.calibrated = 1'b1;
    return w;
  endfunction

  function automatic logic [acdz_pkg::SampleW-1:0] pick_sample();
    int v;
    int sel;
    int off;
    sel = $urandom_range(0, 99);
    off = $urandom_range(0, 6);
    if (sel < 40) begin
      v = $urandom_range(win_lo, win_hi);
    end else if (sel < 55) begin
      v = $urandom_range(0, 65535);
    end else if (sel < 62) begin
      case ($urandom_range(0, 3))
        0:       v = 0;
        1:       v = 65535;
        2:       v = 32767;
        default: v = 32768;
      endcase
    end else if (sel < 85) begin
      case ($urandom_range(0, 4))
        0:       v = int'(cal_min) + int'(reg_dz_min);
        1:       v = int'(cal_center) - int'(reg_dz_center);
        2:       v = int'(cal_center) + int'(reg_dz_center);
        3:       v = int'(cal_max) - int'(reg_dz_max);
        default: v = int'(cal_center);
      endcase
      v = v + off - 3;
    end else begin
      v = ($urandom_range(0, 1) != 0) ? int'(cal_min) : int'(cal_max);
      v = v + off - 3;
    end
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[acdz_pkg::SampleW-1:0];
  endfunction

  function automatic logic [acdz_pkg::SampleW-1:0] pick_deadzone();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 20) return '0;
    if (sel < 50) return acdz_pkg::SampleW'($urandom_range(0, 255));
    if (sel < 80) return acdz_pkg::SampleW'($urandom_range(0, 16'h1FFF));
    if (sel < 95) return acdz_pkg::SampleW'($urandom_range(0, 65535));
    return 16'hFFFF;
  endfunction

  task automatic send_sample(input logic [acdz_pkg::SampleW-1:0] raw);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    push         <= 1'b1;
    raw_sample_i <= raw;
    do @(posedge clk_i); while (full);
    pending_words.push_back(calibrate_sample(raw));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input acdz_pkg::cfg_reg_e idx,
                           input logic [acdz_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      acdz_pkg::CfgFloatMask: reg_float_mask = data[acdz_pkg::MaskW-1:0];
      acdz_pkg::CfgDzMin:     reg_dz_min     = data;
      acdz_pkg::CfgDzCenter:  reg_dz_center  = data;
      acdz_pkg::CfgDzMax:     reg_dz_max     = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int hold;
    hold = 0;
    pop  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        hold = $urandom_range(1, 10) - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected: position %h", scaled_position_o);
        err_cnt++;
      end else begin
        oldest_word = pending_words.pop_front();
        if (scaled_position_o !== oldest_word.position) begin
          $error("scaled_position expected %h actual %h", oldest_word.position,
                 scaled_position_o);
          err_cnt++;
        end
        if (calibrated_o !== oldest_word.calibrated) begin
          $error("calibrated expected %b actual %b", oldest_word.calibrated, calibrated_o);
          err_cnt++;
        end
        if (calibration_changed_o !== oldest_word.changed) begin
          $error("calibration_changed expected %b actual %b", oldest_word.changed,
                 calibration_changed_o);
          err_cnt++;
        end
      end
    end
  end

  task automatic test_unset_points();
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFE);
    send_sample(16'h7FFF);
    send_sample(16'h7FFE);
    send_sample(16'hFFFF);
    send_sample(16'h1234);
    wait_idle();
  endtask

  task automatic test_deadzone_bounds();
    write_reg(acdz_pkg::CfgDzMin, 16'h0100);
    write_reg(acdz_pkg::CfgDzCenter, 16'h0200);
    write_reg(acdz_pkg::CfgDzMax, 16'h0300);
    send_sample(cal_min + reg_dz_min);
    send_sample(cal_min + reg_dz_min + 16'd1);
    send_sample(cal_center - reg_dz_center - 16'd1);
    send_sample(cal_center - reg_dz_center);
    send_sample(cal_center + reg_dz_center);
    send_sample(cal_center + reg_dz_center + 16'd1);
    send_sample(cal_max - reg_dz_max - 16'd1);
    send_sample(cal_max - reg_dz_max);
    wait_idle();
    write_reg(acdz_pkg::CfgDzMin, 16'hFFFF);
    write_reg(acdz_pkg::CfgDzCenter, 16'hFFFF);
    write_reg(acdz_pkg::CfgDzMax, 16'hFFFF);
    send_sample(16'h0800);
    send_sample(16'h1000);
    wait_idle();
  endtask

  task automatic test_frozen_points();
    write_reg(acdz_pkg::CfgDzMin, 16'h0000);
    write_reg(acdz_pkg::CfgDzCenter, 16'h0000);
    write_reg(acdz_pkg::CfgDzMax, 16'h0000);
    write_reg(acdz_pkg::CfgFloatMask, 16'd0);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    wait_idle();
    write_reg(acdz_pkg::CfgFloatMask, 16'd4);
    send_sample(16'hFFFF);
    send_sample(16'h0100);
    send_sample(16'h0500);
    wait_idle();
    write_reg(acdz_pkg::CfgFloatMask, 16'd1);
    send_sample(16'h0000);
    wait_idle();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0 || phase == 7) begin
        write_reg(acdz_pkg::CfgFloatMask, 16'd7);
      end else if ($urandom_range(0, 1) != 0) begin
        write_reg(acdz_pkg::CfgFloatMask, 16'd7);
      end else begin
        write_reg(acdz_pkg::CfgFloatMask, acdz_pkg::CfgDataW'($urandom_range(0, 7)));
      end
      if (phase == 0) begin
        write_reg(acdz_pkg::CfgDzMin, 16'h0000);
        write_reg(acdz_pkg::CfgDzCenter, 16'h0000);
        write_reg(acdz_pkg::CfgDzMax, 16'h0000);
      end else if (phase == 1) begin
        write_reg(acdz_pkg::CfgDzMin, 16'hFFFF);
        write_reg(acdz_pkg::CfgDzCenter, 16'hFFFF);
        write_reg(acdz_pkg::CfgDzMax, 16'hFFFF);
      end else begin
        write_reg(acdz_pkg::CfgDzMin, pick_deadzone());
        write_reg(acdz_pkg::CfgDzCenter, pick_deadzone());
        write_reg(acdz_pkg::CfgDzMax, pick_deadzone());
      end
      win_lo = $urandom_range(0, 65535);
      win_hi = win_lo + (1 << $urandom_range(4, 16));
      if (win_hi > 65535) win_hi = 65535;
      idle_on = (phase == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
      repeat (140) send_sample(pick_sample());
      wait_idle();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = acdz_pkg::CfgFloatMask;
    cfg_data_i     = '0;
    push           = 1'b0;
    raw_sample_i   = '0;
    err_cnt        = 0;
    idle_on        = 1'b1;
    win_lo         = 0;
    win_hi         = 65535;
    reg_float_mask = 3'd7;
    reg_dz_min     = '0;
    reg_dz_center  = '0;
    reg_dz_max     = '0;
    cal_min        = acdz_pkg::UnsetPoint;
    cal_center     = acdz_pkg::UnsetPoint;
    cal_max        = acdz_pkg::UnsetPoint;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_unset_points();
    test_deadzone_bounds();
    test_frozen_points();
    test_random_phases();

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
